// File: rtl/core/sars_pkg.sv
// ----------------------------------------------------------------------------
// sars_pkg
// Types, constants and the off-count function shared by the servo ramp stepper.
// ----------------------------------------------------------------------------
package sars_pkg;

    localparam int CHANNELS_PER_CHIP_DEF = 12;
    localparam int NUM_CHIPS_DEF         = 2;

    // index wide enough for the largest table (16 channels x 2 chips)
    localparam int IDX_MAX_W = 5;

    localparam logic [1:0]        MODE_MAX  = 2'd1;
    localparam logic [1:0]        CHIP_NONE = 2'd0;
    localparam logic [1:0]        CHIP_HIGH = 2'd2;
    localparam logic signed [8:0] ANGLE_MAX = 9'sd180;
    localparam logic signed [8:0] ANGLE_MIN = -9'sd180;

    localparam logic signed [9:0] ANGLE_OFS = 10'sd45;
    // ceil(2^16 * 512 / 225): exact floor for |angle+45| up to 225
    localparam logic [17:0]       OFF_RECIP = 18'd149131;
    localparam int                OFF_SHIFT = 16;

    localparam logic signed [10:0] OFF_MIN = -11'sd307;
    localparam logic signed [10:0] OFF_MAX = 11'sd512;

    typedef struct packed {
        logic                 wr_en;
        logic [IDX_MAX_W-1:0] idx;
        logic signed [8:0]    target;
    } t_step_req;

    typedef struct packed {
        logic signed [8:0] cur_angle;
        logic              reached_notice;
    } t_step_rsp;

    // trunc((angle + 45) * 512 / 225), truncation toward zero
    function automatic logic signed [10:0] off_count(input logic signed [8:0] angle);
        logic signed [9:0] sum;
        logic              neg;
        logic [9:0]        mag;
        logic [27:0]       prod;
        logic [11:0]       quo;
        logic [11:0]       res;
        sum  = 10'(angle) + ANGLE_OFS;
        neg  = sum[9];
        mag  = neg ? 10'(-sum) : 10'(sum);
        prod = 28'(mag) * 28'(OFF_RECIP);
        quo  = prod[OFF_SHIFT +: 12];
        res  = neg ? 12'(-quo) : quo;
        return res[10:0];
    endfunction

endpackage

// File: rtl/core/servo_angle_ramp_stepper.sv
// ----------------------------------------------------------------------------
// servo_angle_ramp_stepper
// Servo slew-rate limiter: steps each channel's angle by at most one degree per request.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken at a clock edge with start high and busy
//   low. busy stays low: a request may be presented on every cycle.
//   Each request gives exactly one result, shown for one cycle with
//   o_result_valid high, after passing through the request register and
//   then the result register.
//   Throughput is one request per cycle; the read-modify-write of the
//   per-channel angle table completes in the request-register cycle, so a
//   following request to the same channel sees the updated angle.
//   The result carries an error status, a PWM off-count write for the
//   pre-step angle, and one-time reached and blocked notices.
//   Reset (synchronous, active low) sets all angles to zero, all reached
//   flags to one and the blocked flag to zero, and drops any request in
//   flight. The receiver cannot stall: results must be taken when shown.
// ----------------------------------------------------------------------------
module servo_angle_ramp_stepper #(
    parameter int CHANNELS_PER_CHIP = sars_pkg::CHANNELS_PER_CHIP_DEF,
    parameter int NUM_CHIPS         = sars_pkg::NUM_CHIPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_chip_select,
    input  logic [3:0]         i_channel,
    input  logic signed [8:0]  i_target_angle,
    input  logic [1:0]         i_mode,
    input  logic               i_run_enable,
    output logic               o_result_valid,
    output logic               o_status,
    output logic               o_pwm_valid,
    output logic [1:0]         o_pwm_chip,
    output logic [3:0]         o_pwm_channel,
    output logic signed [10:0] o_pwm_off_count,
    output logic               o_reached_notice,
    output logic               o_blocked_notice
);

    localparam int TABLE_SIZE = CHANNELS_PER_CHIP * NUM_CHIPS;

    logic              r_vld;
    logic [1:0]        r_chip;
    logic [3:0]        r_chan;
    logic signed [8:0] r_target;
    logic [1:0]        r_mode;
    logic              r_run;
    logic              r_blocked;
    logic              n_blocked;

    logic                r_out_vld;
    logic                r_status;
    logic                r_pwm_valid;
    logic [1:0]          r_pwm_chip;
    logic [3:0]          r_pwm_chan;
    logic signed [10:0]  r_off;
    logic                r_reached;
    logic                r_blk_notice;

    logic                invalid;
    logic                ok;
    logic                do_run;
    logic                do_block;
    logic [sars_pkg::IDX_MAX_W-1:0] chip_ofs;
    sars_pkg::t_step_req step_req;
    sars_pkg::t_step_rsp step_rsp;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_chip   <= i_chip_select;
            r_chan   <= i_channel;
            r_target <= i_target_angle;
            r_mode   <= i_mode;
            r_run    <= i_run_enable;
        end
    end

    assign invalid = (r_mode > sars_pkg::MODE_MAX) ||
                     (r_chip == sars_pkg::CHIP_NONE) ||
                     (3'(r_chip) > 3'(NUM_CHIPS)) ||
                     (5'(r_chan) >= 5'(CHANNELS_PER_CHIP)) ||
                     (r_target > sars_pkg::ANGLE_MAX) ||
                     (r_target < sars_pkg::ANGLE_MIN);
    assign ok       = r_vld & ~invalid;
    assign do_run   = ok & r_run;
    assign do_block = ok & ~r_run;

    assign chip_ofs = (r_chip == sars_pkg::CHIP_HIGH) ?
                      sars_pkg::IDX_MAX_W'(CHANNELS_PER_CHIP) : '0;

    assign step_req.wr_en  = do_run;
    assign step_req.idx    = chip_ofs + sars_pkg::IDX_MAX_W'(r_chan);
    assign step_req.target = r_target;

    sars_chan_table #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (step_req),
        .o_rsp   (step_rsp)
    );

    always_comb begin
        n_blocked = r_blocked;
        if (do_run) begin
            n_blocked = 1'b0;
        end else if (do_block) begin
            n_blocked = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocked <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_blocked <= n_blocked;
            r_out_vld <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= invalid;
        r_pwm_valid  <= do_run;
        r_pwm_chip   <= do_run ? r_chip : 2'd0;
        r_pwm_chan   <= do_run ? r_chan : 4'd0;
        r_off        <= do_run ? sars_pkg::off_count(step_rsp.cur_angle) : '0;
        r_reached    <= do_run & step_rsp.reached_notice;
        r_blk_notice <= do_block & ~r_blocked;
    end

    assign o_result_valid   = r_out_vld;
    assign o_status         = r_status;
    assign o_pwm_valid      = r_pwm_valid;
    assign o_pwm_chip       = r_pwm_chip;
    assign o_pwm_channel    = r_pwm_chan;
    assign o_pwm_off_count  = r_off;
    assign o_reached_notice = r_reached;
    assign o_blocked_notice = r_blk_notice;

    a_result_follows_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |=> o_result_valid)
        else $error("request without result");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status) |->
        (!o_pwm_valid && !o_reached_notice && !o_blocked_notice))
        else $error("error result with side outputs");

    a_run_not_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_pwm_valid) |-> !o_blocked_notice)
        else $error("pwm write and blocked notice together");

    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_pwm_valid) |->
        (o_pwm_off_count >= sars_pkg::OFF_MIN) && (o_pwm_off_count <= sars_pkg::OFF_MAX))
        else $error("off-count out of range");

endmodule

// File: rtl/core/sars_chan_table.sv
// ----------------------------------------------------------------------------
// sars_chan_table
// Per-channel current angle and reached flag; on write, a step of at most one degree toward the target.
// ----------------------------------------------------------------------------
module sars_chan_table #(
    parameter int TABLE_SIZE = sars_pkg::CHANNELS_PER_CHIP_DEF * sars_pkg::NUM_CHIPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sars_pkg::t_step_req i_req,
    output sars_pkg::t_step_rsp o_rsp
);

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    logic signed [8:0] r_angle   [TABLE_SIZE];
    logic              r_reached [TABLE_SIZE];

    logic [IDX_W-1:0]  idx;
    logic signed [8:0] cur;
    logic              reached;
    logic signed [8:0] n_angle;
    logic              n_reached;
    logic              notice;

    assign idx     = i_req.idx[IDX_W-1:0];
    assign cur     = r_angle[idx];
    assign reached = r_reached[idx];

    always_comb begin
        n_angle   = cur;
        n_reached = reached;
        notice    = 1'b0;
        if (cur > i_req.target) begin
            n_angle   = cur - 9'sd1;
            n_reached = 1'b0;
        end else if (cur < i_req.target) begin
            n_angle   = cur + 9'sd1;
            n_reached = 1'b0;
        end else if (!reached) begin
            notice    = 1'b1;
            n_reached = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                r_angle[i]   <= '0;
                r_reached[i] <= 1'b1;
            end
        end else if (i_req.wr_en) begin
            r_angle[idx]   <= n_angle;
            r_reached[idx] <= n_reached;
        end
    end

    assign o_rsp.cur_angle      = cur;
    assign o_rsp.reached_notice = i_req.wr_en & notice;

    a_notice_at_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.reached_notice |-> (o_rsp.cur_angle == i_req.target))
        else $error("reached notice away from target");

    a_step_clears_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.wr_en && (o_rsp.cur_angle != i_req.target))
        |=> !r_reached[$past(idx)])
        else $error("reached flag kept after a step");

    a_step_one_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.wr_en |=>
        (r_angle[$past(idx)] == $past(o_rsp.cur_angle)) ||
        (r_angle[$past(idx)] == $past(o_rsp.cur_angle) + 9'sd1) ||
        (r_angle[$past(idx)] == $past(o_rsp.cur_angle) - 9'sd1))
        else $error("angle moved by more than one degree");

endmodule
